// ===== sv/pptpd_pkg.sv =====
// ----------------------------------------------------------------------------
// pptpd_pkg
// Types, constants and helpers shared by the point to polyline distance block.
// ----------------------------------------------------------------------------
package pptpd_pkg;

   localparam logic [31:0] DEG90  = 32'd754974720;
   localparam logic [31:0] DEG180 = 32'd1509949440;
   localparam logic [31:0] DEG360 = 32'd3019898880;
   localparam logic [31:0] RAD_Q  = 32'd74961321;
   localparam logic [30:0] Q30_ONE = 31'h40000000;
   localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [2:0]  HORNER_LAST = 3'd5;
   localparam logic [1:0]  ADDR_LENGTH_SCALE = 2'd0;
   localparam logic [31:0] SCALE_RESET = 32'd28497790;

   typedef struct packed {
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic [47:0] min_distance;
      logic [47:0] offset_along;
      logic [47:0] total_length;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [32:0] v1x;
      logic signed [32:0] v1y;
      logic signed [32:0] v2x;
      logic signed [32:0] v2y;
      logic signed [32:0] wx;
      logic signed [32:0] wy;
      logic               have_prev;
      logic               last;
   } item_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
   } geo_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] span;
   } geo_rsp_type;

   function automatic logic [31:0] mag33(logic signed [32:0] v);
      logic signed [32:0] n;
      n = v[32] ? -v : v;
      return n[31:0];
   endfunction

   function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MASK48 : s[47:0];
   endfunction

   // ceil(2^32 / d) for the Horner divisors
   function automatic logic [31:0] horner_recip(logic [2:0] i);
      logic [31:0] m;
      unique case (i)
         3'd0: m = 32'd32537632;
         3'd1: m = 32'd47721859;
         3'd2: m = 32'd76695845;
         3'd3: m = 32'd143165577;
         3'd4: m = 32'd357913942;
         default: m = 32'd2147483648;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] horner_div(logic [2:0] i);
      logic [7:0] d;
      unique case (i)
         3'd0: d = 8'd132;
         3'd1: d = 8'd90;
         3'd2: d = 8'd56;
         3'd3: d = 8'd30;
         3'd4: d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/pptpd_front.sv =====
// ----------------------------------------------------------------------------
// pptpd_front
// Accepts vertex items, tracks the previous vertex, forms the difference
// vectors and holds the items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pptpd_front
   import pptpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   output logic     item_valid,
   output item_type item,
   input  logic     take
);

   item_type           queue_ff [2];
   logic               wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic               have_ff, have_in;
   item_type           entry;
   logic               accept, leave;

   assign full       = (cnt_ff == 2'd2);
   assign accept     = push && !full;
   assign item_valid = (cnt_ff != 2'd0);
   assign leave      = take && item_valid;
   assign item       = queue_ff[rd_ff];

   always_comb begin
      entry.qx        = req_data.query_x;
      entry.qy        = req_data.query_y;
      entry.vx        = req_data.vert_x;
      entry.vy        = req_data.vert_y;
      entry.px        = px_ff;
      entry.py        = py_ff;
      entry.v1x       = 33'(req_data.vert_x) - 33'(px_ff);
      entry.v1y       = 33'(req_data.vert_y) - 33'(py_ff);
      entry.v2x       = 33'(req_data.query_x) - 33'(px_ff);
      entry.v2y       = 33'(req_data.query_y) - 33'(py_ff);
      entry.wx        = 33'(req_data.vert_x) - 33'(req_data.query_x);
      entry.wy        = 33'(req_data.vert_y) - 33'(req_data.query_y);
      entry.have_prev = have_ff;
      entry.last      = req_data.last_vertex;
   end

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      have_in = have_ff;
      if (accept) begin
         wr_in = !wr_ff;
         if (req_data.last_vertex) begin
            px_in   = '0;
            py_in   = '0;
            have_in = 1'b0;
         end else begin
            px_in   = req_data.vert_x;
            py_in   = req_data.vert_y;
            have_in = 1'b1;
         end
      end
      if (leave) rd_in = !rd_ff;
      if (accept && !leave) cnt_in = cnt_ff + 2'd1;
      else if (!accept && leave) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
         px_ff   <= '0;
         py_ff   <= '0;
         have_ff <= 1'b0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         cnt_ff  <= cnt_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) queue_ff[wr_ff] <= entry;
   end

endmodule

// ===== sv/pptpd_geo.sv =====
// ----------------------------------------------------------------------------
// pptpd_geo
// Multi-cycle equirectangular distance unit: cosine series, squares,
// bit-serial square root and final scaling.
// ----------------------------------------------------------------------------
module pptpd_geo
   import pptpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] scale,
   input  geo_req_type req,
   output geo_rsp_type rsp
);

   typedef enum logic [12:0] {
      G_IDLE  = 13'h0001,
      G_FOLD  = 13'h0002,
      G_RAD   = 13'h0004,
      G_R2    = 13'h0008,
      G_HMUL  = 13'h0010,
      G_HREC  = 13'h0020,
      G_HCOR  = 13'h0040,
      G_EMUL  = 13'h0080,
      G_SQ    = 13'h0100,
      G_SUM   = 13'h0200,
      G_SQRT  = 13'h0400,
      G_SCALE = 13'h0800,
      G_DONE  = 13'h1000
   } geo_state_type;

   geo_state_type state_ff, state_in;
   logic [31:0] d1_ff, d1_in, dy_ff, dy_in, a_ff, a_in, r_ff, r_in;
   logic [31:0] r2_ff, r2_in, p_ff, p_in, qe_ff, qe_in;
   logic [30:0] t_ff, t_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] s1_ff, s1_in, s2_ff, s2_in, v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [47:0] dist_ff, dist_in;

   logic [63:0] prod, rb;
   logic [64:0] sum;
   logic [39:0] chk;
   logic [31:0] a1, q;

   assign rsp.done = (state_ff == G_DONE);
   assign rsp.span = dist_ff;

   always_comb begin
      state_in = state_ff;
      d1_in = d1_ff; dy_in = dy_ff; a_in = a_ff; r_in = r_ff; r2_in = r2_ff;
      p_in = p_ff; qe_in = qe_ff; t_in = t_ff; step_in = step_ff;
      s1_in = s1_ff; s2_in = s2_ff; v_in = v_ff; res_in = res_ff; bit_in = bit_ff;
      cnt_in = cnt_ff; dist_in = dist_ff;
      prod = '0; rb = '0; sum = '0; chk = '0; a1 = '0; q = '0;
      unique case (state_ff)
         G_IDLE: begin
            if (req.start) begin
               d1_in    = mag33(33'(req.ax) - 33'(req.bx));
               dy_in    = mag33(33'(req.by) - 33'(req.ay));
               a_in     = mag33(33'(req.ax));
               state_in = G_FOLD;
            end
         end
         G_FOLD: begin
            a1       = (a_ff > DEG180) ? DEG360 - a_ff : a_ff;
            a_in     = (a1 > DEG90) ? DEG180 - a1 : a1;
            state_in = G_RAD;
         end
         G_RAD: begin
            prod     = 64'(a_ff) * 64'(RAD_Q);
            r_in     = prod[56:25];
            state_in = G_R2;
         end
         G_R2: begin
            prod     = 64'(r_ff) * 64'(r_ff);
            r2_in    = prod[61:30];
            t_in     = Q30_ONE;
            step_in  = 3'd0;
            state_in = G_HMUL;
         end
         G_HMUL: begin
            prod     = 64'(r2_ff) * 64'(t_ff);
            p_in     = prod[61:30];
            state_in = G_HREC;
         end
         G_HREC: begin
            prod     = 64'(p_ff) * 64'(horner_recip(step_ff));
            qe_in    = prod[63:32];
            state_in = G_HCOR;
         end
         G_HCOR: begin
            chk  = 40'(qe_ff) * 40'(horner_div(step_ff));
            q    = (chk > 40'(p_ff)) ? qe_ff - 32'd1 : qe_ff;
            t_in = (q > 32'(Q30_ONE)) ? '0 : Q30_ONE - q[30:0];
            step_in = step_ff + 3'd1;
            state_in = (step_ff == HORNER_LAST) ? G_EMUL : G_HMUL;
         end
         G_EMUL: begin
            prod     = 64'(dy_ff) * 64'(t_ff);
            dy_in    = prod[61:30];
            state_in = G_SQ;
         end
         G_SQ: begin
            s1_in    = 64'(d1_ff) * 64'(d1_ff);
            s2_in    = 64'(dy_ff) * 64'(dy_ff);
            state_in = G_SUM;
         end
         G_SUM: begin
            sum      = 65'(s1_ff) + 65'(s2_ff);
            v_in     = sum[64] ? '1 : sum[63:0];
            res_in   = '0;
            bit_in   = 64'h4000_0000_0000_0000;
            cnt_in   = 5'd0;
            state_in = G_SQRT;
         end
         G_SQRT: begin
            rb = res_ff + bit_ff;
            if (v_ff >= rb) begin
               v_in   = v_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = G_SCALE;
         end
         G_SCALE: begin
            prod     = 64'(scale) * 64'(res_ff[31:0]);
            dist_in  = 48'(prod >> 23);
            state_in = G_DONE;
         end
         G_DONE: state_in = G_IDLE;
         default: state_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= G_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      d1_ff <= d1_in; dy_ff <= dy_in; a_ff <= a_in; r_ff <= r_in; r2_ff <= r2_in;
      p_ff <= p_in; qe_ff <= qe_in; t_ff <= t_in; step_ff <= step_in;
      s1_ff <= s1_in; s2_ff <= s2_in; v_ff <= v_in; res_ff <= res_in; bit_ff <= bit_in;
      cnt_ff <= cnt_in; dist_ff <= dist_in;
   end

endmodule

// ===== sv/pptpd_back.sv =====
// ----------------------------------------------------------------------------
// pptpd_back
// Sequencer that takes queued items, runs the foot point test and fraction
// divider, drives the distance unit and keeps the running best and length.
// ----------------------------------------------------------------------------
module pptpd_back
   import pptpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        take,
   output geo_req_type geo_req,
   input  geo_rsp_type geo_rsp,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data
);

   typedef enum logic [20:0] {
      B_IDLE  = 21'h000001,
      B_DOT1  = 21'h000002,
      B_DOT1E = 21'h000004,
      B_DOT2  = 21'h000008,
      B_DOT2E = 21'h000010,
      B_FT1   = 21'h000020,
      B_FT2   = 21'h000040,
      B_FT3   = 21'h000080,
      B_NORM  = 21'h000100,
      B_DIV   = 21'h000200,
      B_OFS   = 21'h000400,
      B_NX    = 21'h000800,
      B_GNQ_S = 21'h001000,
      B_GNQ_W = 21'h002000,
      B_GPN_S = 21'h004000,
      B_GPN_W = 21'h008000,
      B_GPV_S = 21'h010000,
      B_GPV_W = 21'h020000,
      B_GVQ_S = 21'h040000,
      B_GVQ_W = 21'h080000,
      B_OUT   = 21'h100000
   } back_state_type;

   back_state_type     state_ff, state_in;
   item_type           e_ff, e_in;
   logic [63:0]        pa_ff, pa_in, pb_ff, pb_in, num_ff, num_in, den_ff, den_in;
   logic               pos1_ff, pos1_in;
   logic [31:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [32:0]        rem_ff, rem_in, quot_ff, quot_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [47:0]        best_ff, best_in, ofs_ff, ofs_in, run_ff, run_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               k, ge, sp_z, sp_n, sq_z, sq_n;
   logic [31:0]        bx, by;
   logic [32:0]        diff, tq;
   logic [64:0]        ox, oy;
   logic signed [32:0] sx, sy;

   // sign of a1*b1 + a2*b2 > 0, given the two magnitude products
   function automatic logic dot_pos(logic signed [32:0] a1, logic signed [32:0] b1,
                                    logic signed [32:0] a2, logic signed [32:0] b2,
                                    logic [63:0] p, logic [63:0] q);
      logic pz, pn, qz, qn, r;
      pz = (a1 == 0) || (b1 == 0);
      pn = a1[32] ^ b1[32];
      qz = (a2 == 0) || (b2 == 0);
      qn = a2[32] ^ b2[32];
      priority if (pz)            r = !qz && !qn;
      else if (qz || (pn == qn))  r = !pn;
      else if (p > q)             r = !pn;
      else if (p < q)             r = !qn;
      else                        r = 1'b0;
      return r;
   endfunction

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff; e_in = e_ff; pa_in = pa_ff; pb_in = pb_ff;
      num_in = num_ff; den_in = den_ff; pos1_in = pos1_ff; ax_in = ax_ff; ay_in = ay_ff;
      rem_in = rem_ff; quot_in = quot_ff; cnt_in = cnt_ff; nx_in = nx_ff; ny_in = ny_ff;
      best_in = best_ff; ofs_in = ofs_ff; run_in = run_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      take = 1'b0;
      geo_req = '0;
      k = 1'b0; ge = 1'b0; bx = '0; by = '0; diff = '0; tq = '0; ox = '0; oy = '0;
      sx = '0; sy = '0;
      sp_z = (e_ff.v1x == 0) || (e_ff.v2x == 0);
      sp_n = e_ff.v1x[32] ^ e_ff.v2x[32];
      sq_z = (e_ff.v1y == 0) || (e_ff.v2y == 0);
      sq_n = e_ff.v1y[32] ^ e_ff.v2y[32];
      if (pop && rsp_valid_ff) rsp_valid_in = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (item_valid) begin
               take     = 1'b1;
               e_in     = item;
               state_in = item.have_prev ? B_DOT1 : B_GVQ_S;
            end
         end
         B_DOT1: begin
            pa_in    = 64'(mag33(e_ff.v1x)) * 64'(mag33(e_ff.v2x));
            pb_in    = 64'(mag33(e_ff.v1y)) * 64'(mag33(e_ff.v2y));
            state_in = B_DOT1E;
         end
         B_DOT1E: begin
            pos1_in  = dot_pos(e_ff.v1x, e_ff.v2x, e_ff.v1y, e_ff.v2y, pa_ff, pb_ff);
            state_in = B_DOT2;
         end
         B_DOT2: begin
            pa_in    = 64'(mag33(e_ff.v1x)) * 64'(mag33(e_ff.wx));
            pb_in    = 64'(mag33(e_ff.v1y)) * 64'(mag33(e_ff.wy));
            state_in = B_DOT2E;
         end
         B_DOT2E: begin
            if (pos1_ff && dot_pos(e_ff.v1x, e_ff.wx, e_ff.v1y, e_ff.wy, pa_ff, pb_ff))
               state_in = B_FT1;
            else
               state_in = B_GPV_S;
         end
         B_FT1: begin
            ax_in    = mag33(e_ff.v1x);
            ay_in    = mag33(e_ff.v1y);
            k        = ax_in[31] | ay_in[31];
            ax_in    = ax_in >> k;
            ay_in    = ay_in >> k;
            bx       = mag33(e_ff.v2x) >> k;
            by       = mag33(e_ff.v2y) >> k;
            pa_in    = 64'(ax_in) * 64'(bx);
            pb_in    = 64'(ay_in) * 64'(by);
            state_in = B_FT2;
         end
         B_FT2: begin
            den_in = 64'(ax_ff) * 64'(ax_ff) + 64'(ay_ff) * 64'(ay_ff);
            priority if ((sp_z || !sp_n) && (sq_z || !sq_n))
               num_in = (sp_z ? 64'd0 : pa_ff) + (sq_z ? 64'd0 : pb_ff);
            else if (!sp_z && !sp_n)
               num_in = (pa_ff > pb_ff) ? pa_ff - pb_ff : 64'd0;
            else if (!sq_z && !sq_n)
               num_in = (pb_ff > pa_ff) ? pb_ff - pa_ff : 64'd0;
            else
               num_in = 64'd0;
            state_in = B_FT3;
         end
         B_FT3: begin
            if (num_ff > den_ff) num_in = den_ff;
            state_in = B_NORM;
         end
         B_NORM: begin
            if (den_ff[63:32] != 32'd0) begin
               den_in = den_ff >> 1;
               num_in = num_ff >> 1;
            end else begin
               rem_in   = {1'b0, num_ff[31:0]};
               quot_in  = '0;
               cnt_in   = 6'd0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            ge      = (rem_ff >= {1'b0, den_ff[31:0]});
            diff    = ge ? rem_ff - {1'b0, den_ff[31:0]} : rem_ff;
            quot_in = {quot_ff[31:0], ge};
            rem_in  = {diff[31:0], 1'b0};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) state_in = B_OFS;
         end
         B_OFS: begin
            tq       = (den_ff[31:0] == 32'd0) ? 33'd0 : quot_ff;
            ox       = 65'(mag33(e_ff.v1x)) * 65'(tq);
            oy       = 65'(mag33(e_ff.v1y)) * 65'(tq);
            ax_in    = ox[63:32];
            ay_in    = oy[63:32];
            state_in = B_NX;
         end
         B_NX: begin
            sx = e_ff.v1x[32] ? 33'(e_ff.px) - 33'(ax_ff) : 33'(e_ff.px) + 33'(ax_ff);
            sy = e_ff.v1y[32] ? 33'(e_ff.py) - 33'(ay_ff) : 33'(e_ff.py) + 33'(ay_ff);
            nx_in    = sx[31:0];
            ny_in    = sy[31:0];
            state_in = B_GNQ_S;
         end
         B_GNQ_S: begin
            geo_req  = '{start: 1'b1, ax: nx_ff, ay: ny_ff, bx: e_ff.qx, by: e_ff.qy};
            state_in = B_GNQ_W;
         end
         B_GNQ_W: begin
            if (geo_rsp.done) begin
               if (geo_rsp.span < best_ff) begin
                  best_in  = geo_rsp.span;
                  state_in = B_GPN_S;
               end else begin
                  state_in = B_GPV_S;
               end
            end
         end
         B_GPN_S: begin
            geo_req  = '{start: 1'b1, ax: e_ff.px, ay: e_ff.py, bx: nx_ff, by: ny_ff};
            state_in = B_GPN_W;
         end
         B_GPN_W: begin
            if (geo_rsp.done) begin
               ofs_in   = sat_add48(run_ff, geo_rsp.span);
               state_in = B_GPV_S;
            end
         end
         B_GPV_S: begin
            geo_req  = '{start: 1'b1, ax: e_ff.px, ay: e_ff.py, bx: e_ff.vx, by: e_ff.vy};
            state_in = B_GPV_W;
         end
         B_GPV_W: begin
            if (geo_rsp.done) begin
               run_in   = sat_add48(run_ff, geo_rsp.span);
               state_in = B_GVQ_S;
            end
         end
         B_GVQ_S: begin
            geo_req  = '{start: 1'b1, ax: e_ff.vx, ay: e_ff.vy, bx: e_ff.qx, by: e_ff.qy};
            state_in = B_GVQ_W;
         end
         B_GVQ_W: begin
            if (geo_rsp.done) begin
               if (geo_rsp.span < best_ff) begin
                  best_in = geo_rsp.span;
                  ofs_in  = run_ff;
               end
               state_in = e_ff.last ? B_OUT : B_IDLE;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || pop) begin
               rsp_in.min_distance = best_ff;
               rsp_in.offset_along = ofs_ff;
               rsp_in.total_length = run_ff;
               rsp_valid_in = 1'b1;
               best_in  = MASK48;
               ofs_in   = '0;
               run_in   = '0;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         best_ff      <= MASK48;
         ofs_ff       <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         ofs_ff       <= ofs_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in; pa_ff <= pa_in; pb_ff <= pb_in; num_ff <= num_in; den_ff <= den_in;
      pos1_ff <= pos1_in; ax_ff <= ax_in; ay_ff <= ay_in; rem_ff <= rem_in;
      quot_ff <= quot_in; cnt_ff <= cnt_in; nx_ff <= nx_in; ny_ff <= ny_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/point_to_polyline_distance.sv =====
// ----------------------------------------------------------------------------
// point_to_polyline_distance
// Nearest distance from a query point to a polyline, equirectangular rule.
// ----------------------------------------------------------------------------
// Vertices enter one item at a time through a two-entry queue; one result
// (distance, offset along the line, total length, all 1/256 m) leaves on the
// item marked last_vertex. Each item is worked by a sequencer that shares one
// distance unit (cosine series of 6 Horner steps, 32-step square root) among
// its calls: a vertex with a foot point also runs the normalizing shift (up to
// 31 shifts) and the bit-serial fraction divider. A last vertex then hands out
// its result, and waits while an earlier result has not yet been popped.
// length_scale sits at address 0 of the register port.
module point_to_polyline_distance
   import pptpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] scale_ff, scale_in;
   logic        item_valid, take;
   item_type    item;
   geo_req_type geo_req;
   geo_rsp_type geo_rsp;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_LENGTH_SCALE) ? scale_ff : 32'd0;

   always_comb begin
      scale_in = scale_ff;
      if (psel && penable && pwrite && (paddr == ADDR_LENGTH_SCALE)) scale_in = pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) scale_ff <= SCALE_RESET;
      else       scale_ff <= scale_in;
   end

   pptpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .take       (take)
   );

   pptpd_geo u_geo (
      .clock (clock),
      .reset (reset),
      .scale (scale_ff),
      .req   (geo_req),
      .rsp   (geo_rsp)
   );

   pptpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .geo_req    (geo_req),
      .geo_rsp    (geo_rsp),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== test/point_to_polyline_distance_tb.sv =====
// ----------------------------------------------------------------------------
// point_to_polyline_distance_tb
// Self-checking bench for the point to polyline nearest distance block.
// ----------------------------------------------------------------------------
// Polylines are pushed vertex by vertex with random gaps; each result popped
// is compared with a bit-accurate prediction of the distance, offset and total
// length. length_scale is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module point_to_polyline_distance_tb
   import pptpd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint MAXC = 64'sd1509949440;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_data;
   logic        empty;
   logic        pop;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   point_to_polyline_distance dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [31:0] scale_q;
   longint      last_px, last_py;
   bit          seen_vertex;
   logic [63:0] near_dist, near_offset, path_length;

   rsp_type     pending_results[$];
   int          error_count;
   int          idle_count;
   bit          calm;
   bit          drain_pop;

   function automatic logic [63:0] mag64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic logic [63:0] add_sat48(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
   endfunction

   function automatic longint cosine_q30(longint ang);
      longint divs[6];
      logic [63:0] a;
      logic [63:0] r;
      longint r2, t;
      bit neg;
      divs = '{132, 90, 56, 30, 12, 2};
      a = mag64(ang);
      neg = 0;
      if (a > 64'd1509949440) a = 64'd3019898880 - a;
      if (a > 64'd754974720) begin
         a = 64'd1509949440 - a;
         neg = 1;
      end
      r = (a * 64'd74961321) >> 25;
      r2 = longint'((r * r) >> 30);
      t = 64'sd1 << 30;
      for (int i = 0; i < 6; i++) t = (64'sd1 << 30) - ((r2 * t) / (64'sd1 << 30)) / divs[i];
      if (t < 0) t = 0;
      if (t > (64'sd1 << 30)) t = 64'sd1 << 30;
      return neg ? -t : t;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] surface_dist(longint ax, longint ay, longint bx, longint by);
      longint d1, e;
      logic [63:0] u1, u2, s1, total;
      logic [127:0] prod;
      d1 = ax - bx;
      e = ((by - ay) * cosine_q30(ax)) / (64'sd1 << 30);
      u1 = mag64(d1);
      u2 = mag64(e);
      s1 = u1 * u1;
      total = s1 + u2 * u2;
      if (total < s1) total = '1;
      prod = {96'd0, scale_q} * {64'd0, int_sqrt(total)};
      return prod[86:23];
   endfunction

   function automatic int dot_direction(longint ax, longint ay, longint bx, longint by);
      int sp, sq;
      logic [63:0] p, q;
      sp = sign_of(ax) * sign_of(bx);
      sq = sign_of(ay) * sign_of(by);
      p = mag64(ax) * mag64(bx);
      q = mag64(ay) * mag64(by);
      if (sp == 0) return sq;
      if (sq == 0 || sp == sq) return sp;
      if (p > q) return sp;
      if (p < q) return sq;
      return 0;
   endfunction

   function automatic void clear_polyline();
      last_px = 0;
      last_py = 0;
      seen_vertex = 0;
      near_dist = 64'hFFFF_FFFF_FFFF;
      near_offset = 0;
      path_length = 0;
   endfunction

   function automatic void predict_vertex(req_type it);
      longint qx, qy, vx, vy, v1x, v1y, v2x, v2y, nx, ny;
      int k, sp, sq;
      logic [63:0] ax, ay, p, q, num, den, t, ox, oy, d;
      rsp_type r;
      qx = it.query_x;
      qy = it.query_y;
      vx = it.vert_x;
      vy = it.vert_y;
      if (seen_vertex) begin
         v1x = vx - last_px;
         v1y = vy - last_py;
         v2x = qx - last_px;
         v2y = qy - last_py;
         if (dot_direction(v1x, v1y, v2x, v2y) > 0 &&
             dot_direction(v1x, v1y, vx - qx, vy - qy) > 0) begin
            k = (mag64(v1x) >= 64'h8000_0000 || mag64(v1y) >= 64'h8000_0000) ? 1 : 0;
            ax = mag64(v1x) >> k;
            ay = mag64(v1y) >> k;
            p = ax * (mag64(v2x) >> k);
            q = ay * (mag64(v2y) >> k);
            sp = sign_of(v1x) * sign_of(v2x);
            sq = sign_of(v1y) * sign_of(v2y);
            den = ax * ax + ay * ay;
            t = 0;
            if (sp >= 0 && sq >= 0) num = (sp != 0 ? p : 0) + (sq != 0 ? q : 0);
            else if (sp > 0) num = (p > q) ? p - q : 0;
            else if (sq > 0) num = (q > p) ? q - p : 0;
            else num = 0;
            if (num > den) num = den;
            while (den >= 64'h1_0000_0000) begin
               den = den >> 1;
               num = num >> 1;
            end
            if (den != 0) t = (num << 32) / den;
            ox = (mag64(v1x) * t) >> 32;
            oy = (mag64(v1y) * t) >> 32;
            nx = last_px + ((v1x < 0) ? -longint'(ox) : longint'(ox));
            ny = last_py + ((v1y < 0) ? -longint'(oy) : longint'(oy));
            d = surface_dist(nx, ny, qx, qy);
            if (d < near_dist) begin
               near_dist = d;
               near_offset = add_sat48(path_length, surface_dist(last_px, last_py, nx, ny));
            end
         end
         path_length = add_sat48(path_length, surface_dist(last_px, last_py, vx, vy));
      end
      d = surface_dist(vx, vy, qx, qy);
      if (d < near_dist) begin
         near_dist = d;
         near_offset = path_length;
      end
      last_px = vx;
      last_py = vy;
      seen_vertex = 1;
      if (it.last_vertex) begin
         r.min_distance = near_dist[47:0];
         r.offset_along = near_offset[47:0];
         r.total_length = path_length[47:0];
         pending_results.push_back(r);
         clear_polyline();
      end
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // result side
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result item", $realtime);
               error_count++;
            end else begin
               rsp_type w;
               w = pending_results.pop_front();
               if (rsp_data.min_distance !== w.min_distance)
                  report_mismatch("min_distance", rsp_data.min_distance, w.min_distance);
               if (rsp_data.offset_along !== w.offset_along)
                  report_mismatch("offset_along", rsp_data.offset_along, w.offset_along);
               if (rsp_data.total_length !== w.total_length)
                  report_mismatch("total_length", rsp_data.total_length, w.total_length);
            end
         end
         pop <= drain_pop || calm || ($urandom_range(99) >= 11);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || psel) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_scale(logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= ADDR_LENGTH_SCALE;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      scale_q = value;
   endtask

   task automatic send_vertex(req_type it);
      while (!calm && $urandom_range(99) < 11) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_data <= it;
      do @(posedge clock); while (full);
      predict_vertex(it);
   endtask

   task automatic wait_idle();
      push <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $signed($urandom_range(32'd3019898880)) - 32'sd1509949440;
         1: return $urandom_range(1) ? 32'sd1509949440 : -32'sd1509949440;
         default: return $signed($urandom_range(2000)) - 32'sd1000;
      endcase
   endfunction

   typedef struct {
      req_type     it;
      bit          check;
      rsp_type     want;
   } step_row;

   step_row directed[$];

   function automatic req_type mk(longint qx, longint qy, longint vx, longint vy, bit l);
      req_type r;
      r.query_x = 32'(qx);
      r.query_y = 32'(qy);
      r.vert_x = 32'(vx);
      r.vert_y = 32'(vy);
      r.last_vertex = l;
      return r;
   endfunction

   function automatic void add_row(req_type it, bit check, rsp_type want);
      step_row s;
      s.it = it;
      s.check = check;
      s.want = want;
      directed.push_back(s);
   endfunction

   initial begin
      req_type it;
      rsp_type none;
      int n_lines, n_verts, mode;
      logic [31:0] scales[4];
      error_count = 0;
      idle_count = 0;
      calm = 0;
      drain_pop = 0;
      reset = 1;
      push = 0;
      pop = 0;
      req_data = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      none = '0;
      scale_q = SCALE_RESET;
      clear_polyline();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows; fixed results where plain to see
      add_row(mk(0, 0, 0, 0, 1), 1, '{48'd0, 48'd0, 48'd0});
      add_row(mk(MAXC, MAXC, MAXC, MAXC, 1), 1, '{48'd0, 48'd0, 48'd0});
      add_row(mk(-MAXC, -MAXC, MAXC, MAXC, 1), 0, none);
      add_row(mk(MAXC, -MAXC, -MAXC, MAXC, 1), 0, none);
      add_row(mk(100, 100, 0, 0, 0), 0, none);
      add_row(mk(100, 100, 0, 0, 0), 0, none);
      add_row(mk(100, 100, 1000, 0, 1), 0, none);
      add_row(mk(500, 800, 0, 0, 0), 0, none);
      add_row(mk(500, 800, 1000, 0, 0), 0, none);
      add_row(mk(-500, 300, 1000, 1000, 1), 0, none);
      add_row(mk(0, 0, -MAXC, -MAXC, 0), 0, none);
      add_row(mk(0, 0, MAXC, MAXC, 0), 0, none);
      add_row(mk(0, 0, -MAXC, MAXC, 1), 0, none);
      add_row(mk(10, 5, 0, 0, 0), 0, none);
      add_row(mk(10, 5, 20, 0, 0), 0, none);
      add_row(mk(10, 5, 0, 0, 1), 0, none);
      add_row(mk(32'sd754974720, 0, 32'sd754974720, 0, 0), 0, none);
      add_row(mk(32'sd754974720, 7, 32'sd754974720, 9000, 1), 0, none);
      foreach (directed[i]) begin
         send_vertex(directed[i].it);
         if (directed[i].check && pending_results[$] !== directed[i].want) begin
            $display("%0t directed row %0d: prediction disagrees with fixed value", $realtime, i);
            error_count++;
         end
      end
      wait_idle();

      scales = '{32'd0, 32'hFFFF_FFFF, 32'd28497790, 32'd1};
      for (int ph = 0; ph < 4; ph++) begin
         write_scale(ph == 3 ? $urandom : scales[ph]);
         calm = (ph == 2);
         n_lines = 0;
         while (n_lines < 60) begin
            n_verts = $urandom_range(99) < 20 ? 1 : $urandom_range(6, 2);
            mode = $urandom_range(9) < 6 ? 2 : ($urandom_range(3) == 0 ? 1 : 0);
            for (int v = 0; v < n_verts; v++) begin
               it.query_x = rand_coord(mode);
               it.query_y = rand_coord(mode);
               if (v > 0 && $urandom_range(5) != 0) begin
                  it.query_x = req_data.query_x;
                  it.query_y = req_data.query_y;
               end
               it.vert_x = rand_coord(mode);
               it.vert_y = rand_coord(mode);
               if (v > 0 && $urandom_range(9) == 0) begin
                  it.vert_x = 32'(last_px);
                  it.vert_y = 32'(last_py);
               end
               it.last_vertex = (v == n_verts - 1);
               send_vertex(it);
            end
            n_lines++;
         end
         wait_idle();
      end

      drain_pop = 1;
      repeat (400) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
